FILE: src/olar_pkg.sv
// olar_pkg: shared constants and types of the ordered list block
// command and status codes, queue entry type and sizing defaults
// no dependencies
package olar_pkg;

   // sizing defaults
   localparam int DEPTH_DEF   = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int VALUE_W     = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 6;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // one classified command waiting for the back end
   typedef struct packed {
      logic [CMD_W-1:0]   op;
      logic [VALUE_W-1:0] value;
   } job_type;

   // queue status seen by the front end and the back end
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: src/olar_front.sv
// olar_front: input side of the ordered list block
// accepts request transfers, drops unused command codes, pushes jobs to the queue
// depends on olar_pkg
module olar_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [olar_pkg::VALUE_W-1:0]  req_tdata,   // value
   input  logic [olar_pkg::CMD_W-1:0]    req_tuser,   // command
   input  olar_pkg::qstat_type           qstat,
   output logic                          push,
   output olar_pkg::job_type             push_job
);

   logic accept;
   logic known_cmd;

   // take a transfer whenever the queue has room
   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   // classify: unused codes are consumed without a job
   always_comb begin
      known_cmd = req_tuser inside {olar_pkg::CMD_APPEND, olar_pkg::CMD_REMOVE,
                                    olar_pkg::CMD_DUMP};
   end

   assign push           = accept && known_cmd;
   assign push_job.op    = req_tuser;
   assign push_job.value = req_tdata;

endmodule

FILE: src/olar_queue.sv
// olar_queue: short job queue between front end and back end
// register based fifo of olar_pkg::QUEUE_DEPTH jobs
// depends on olar_pkg
module olar_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  olar_pkg::job_type    push_job,
   input  logic                 pop,
   output olar_pkg::job_type    pop_job,
   output olar_pkg::qstat_type  qstat
);

   localparam int QAW = (olar_pkg::QUEUE_DEPTH > 1) ? $clog2(olar_pkg::QUEUE_DEPTH) : 1;
   localparam int QFW = $clog2(olar_pkg::QUEUE_DEPTH + 1);

   olar_pkg::job_type slot_ff [olar_pkg::QUEUE_DEPTH];
   logic [QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFW-1:0]    fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign qstat.full  = (fill_ff == QFW'(olar_pkg::QUEUE_DEPTH));
   assign qstat.empty = (fill_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_job     = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(olar_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(olar_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: src/olar_back.sv
// olar_back: execution side of the ordered list block
// holds the list memory and count, runs append, remove scan and dump, drives results
// depends on olar_pkg
module olar_back #(
   parameter int DEPTH = olar_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  olar_pkg::qstat_type             qstat,
   input  olar_pkg::job_type               job,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [olar_pkg::STATUS_W-1:0]   rsp_status,
   output logic [olar_pkg::VALUE_W-1:0]    rsp_entry,
   output logic [olar_pkg::OCC_W-1:0]      rsp_occ,
   output logic                            rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   // list memory, head at address zero
   logic [olar_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [olar_pkg::VALUE_W-1:0] rd_data_ff;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [olar_pkg::VALUE_W-1:0] wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;

   logic [1:0]                   state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         found_ff, found_in;
   logic [olar_pkg::VALUE_W-1:0] target_ff, target_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [olar_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [olar_pkg::VALUE_W-1:0] rsp_entry_ff;
   logic [olar_pkg::OCC_W-1:0]   rsp_occ_ff;
   logic                         rsp_last_ff;

   logic                         load;
   logic [olar_pkg::STATUS_W-1:0] ld_status;
   logic [olar_pkg::VALUE_W-1:0] ld_entry;
   logic                         ld_last;
   logic [CW-1:0]                ld_count;

   logic                         out_free;
   logic [CW-1:0]                data_idx;
   logic [CW-1:0]                shift_idx;
   logic                         last_data;
   logic                         match;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // during a scan the read data belongs to the entry before idx
   assign data_idx  = idx_ff - CW'(1);
   assign shift_idx = idx_ff - CW'(2);
   assign last_data = (data_idx == count_ff - CW'(1));
   assign match     = (rd_data_ff == target_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      target_in = target_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      pop       = 1'b0;
      load      = 1'b0;
      ld_status = olar_pkg::ST_OK;
      ld_entry  = '0;
      ld_last   = 1'b1;
      ld_count  = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (!qstat.empty && out_free) begin
               pop = 1'b1;
               case (job.op)
                  olar_pkg::CMD_APPEND: begin
                     load = 1'b1;
                     if (count_ff >= CW'(DEPTH)) begin
                        ld_status = olar_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = job.value;
                        count_in = count_ff + CW'(1);
                        ld_count = count_ff + CW'(1);
                     end
                  end
                  olar_pkg::CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = olar_pkg::ST_NOTFOUND;
                     end else begin
                        rd_en     = 1'b1;
                        idx_in    = CW'(1);
                        found_in  = 1'b0;
                        target_in = job.value;
                        state_in  = S_SCAN;
                     end
                  end
                  olar_pkg::CMD_DUMP: begin
                     if (count_ff == '0) begin
                        load      = 1'b1;
                        ld_status = olar_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = '0;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (last_data) begin
               // final entry: close the scan once the result register is free
               if (out_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = shift_idx[AW-1:0];
                  end
                  if (found_ff || match) begin
                     count_in = count_ff - CW'(1);
                     ld_count = count_ff - CW'(1);
                  end else begin
                     ld_status = olar_pkg::ST_NOTFOUND;
                  end
               end
            end else begin
               // after the hit every entry moves one place towards the head
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = shift_idx[AW-1:0];
               end else if (match) begin
                  found_in = 1'b1;
               end
               rd_en   = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end
         end
         S_DUMP: begin
            if (out_free) begin
               load     = 1'b1;
               ld_entry = rd_data_ff;
               ld_last  = (idx_ff == count_ff - CW'(1));
               if (ld_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff[AW-1:0] + AW'(1);
                  idx_in  = idx_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      target_ff <= target_in;
      if (load) begin
         rsp_status_ff <= ld_status;
         rsp_entry_ff  <= ld_entry;
         rsp_occ_ff    <= olar_pkg::OCC_W'(ld_count);
         rsp_last_ff   <= ld_last;
      end
   end

   // list memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_occ    = rsp_occ_ff;
   assign rsp_last   = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + CW'(1) ||
                         count_ff == $past(count_ff) - CW'(1)))
      else $error("list count moved by more than one");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("memory write beyond the list tail");

   a_dump_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (idx_ff < count_ff))
      else $error("dump index beyond the list tail");

endmodule

FILE: src/ordered_list_append_remove.sv
// ordered list with append, remove and dump; one job at a time in the back end
// path: an append result is registered after the job queue; a remove scans the list
// (one memory read per entry in the scan); dump gives one entry a cycle while rsp_tready holds
// throughput: append one per cycle while results are taken; no job starts mid remove or dump
// reset: empties the list, the job queue and the result register; memory is not cleared
// depends on olar_pkg, olar_front, olar_queue, olar_back
module ordered_list_append_remove #(
   parameter int DEPTH = olar_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [olar_pkg::VALUE_W-1:0]    req_tdata,   // [31:0] value
   input  logic [olar_pkg::CMD_W-1:0]      req_tuser,   // [1:0] command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // [31:0] entry, [37:32] occupancy, zero pad
   output logic [olar_pkg::STATUS_W-1:0]   rsp_tuser,   // [1:0] status
   output logic                            rsp_tlast
);

   olar_pkg::qstat_type          qstat;
   olar_pkg::job_type            push_job;
   olar_pkg::job_type            pop_job;
   logic                         push;
   logic                         pop;
   logic [olar_pkg::VALUE_W-1:0] rsp_entry;
   logic [olar_pkg::OCC_W-1:0]   rsp_occ;

   // request side
   olar_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_job   (push_job)
   );

   // decoupling queue
   olar_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   // list engine
   olar_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .job        (pop_job),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_entry  (rsp_entry),
      .rsp_occ    (rsp_occ),
      .rsp_last   (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {2'b00, rsp_occ, rsp_entry};

endmodule
